FILE: sv/assert_macros.svh
// Assertion macros shared by the post-processor modules.
// Include this file by name inside module bodies that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: sv/pmpp_pkg.sv
`timescale 1ns / 1ps
// Package for the power meter post-processor: widths, register indexes and
// the controller-to-datapath command and status types. Depends on nothing.
package pmpp_pkg;

	localparam int RawW   = 24;
	localparam int GainW  = 32;
	localparam int PowW   = 40;
	localparam int HalfW  = 20;
	localparam int AppW   = 41;
	localparam int PfW    = 16;
	localparam int AccW   = 48;
	localparam int SqW    = 82;
	localparam int DivW   = 56;
	localparam int DataW  = 32;
	localparam int AddrW  = 4;

	localparam logic [GainW-1:0] GainReset = 32'h0001_0000;

	// Power factor limits in Q1.15.
	localparam logic signed [PfW-1:0] PfMax = 16'sh7FFF;
	localparam logic signed [PfW-1:0] PfMin = 16'sh8000;

	localparam logic [AddrW-1:0] RegActiveGain   = 4'h0;
	localparam logic [AddrW-1:0] RegReactiveGain = 4'h4;
	localparam logic [AddrW-1:0] RegEnergyGain   = 4'h8;

	// Number of square root iterations (one result bit each) and divide steps.
	localparam int SqrtSteps = 41;
	localparam int DivSteps  = 56;

	typedef struct packed {
		logic load;      // capture the input item
		logic scale;     // scale readings
		logic sq_add;    // low partial squares
		logic sq_hi;     // add the high partial squares
		logic sqrt_init; // start the root
		logic sqrt_step; // one root bit
		logic div_init;  // start the division
		logic div_step;  // one quotient bit
		logic finish;    // form the result and update the accumulator
	} pmpp_cmd_t;

	typedef struct packed {
		logic sqrt_last;
		logic div_last;
	} pmpp_stat_t;

endpackage

FILE: sv/pmpp_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine of the post-processor: sequences the datapath.
// Depends on pmpp_pkg and assert_macros.svh.
module pmpp_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	output logic                out_valid,
	input  logic                out_stall,
	output pmpp_pkg::pmpp_cmd_t cmd,
	input  pmpp_pkg::pmpp_stat_t stat
);
	import pmpp_pkg::*;
	`include "assert_macros.svh"

	typedef enum logic [8:0] {
		StIdle  = 9'b0_0000_0001,
		StScale = 9'b0_0000_0010,
		StSum   = 9'b0_0000_0100,
		StSqHi  = 9'b0_0000_1000,
		StSqIni = 9'b0_0001_0000,
		StSqrt  = 9'b0_0010_0000,
		StDvIni = 9'b0_0100_0000,
		StDiv   = 9'b0_1000_0000,
		StFin   = 9'b1_0000_0000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;

	// The output register frees once its transfer completes.
	logic out_free;
	assign out_free = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != StIdle);
	assign out_valid = out_valid_q;

	// Next state and commands.
	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			StIdle: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = StScale;
				end
			end
			StScale: begin
				cmd.scale = 1'b1;
				state_d = StSum;
			end
			StSum: begin
				cmd.sq_add = 1'b1;
				state_d = StSqHi;
			end
			StSqHi: begin
				cmd.sq_hi = 1'b1;
				state_d = StSqIni;
			end
			StSqIni: begin
				cmd.sqrt_init = 1'b1;
				state_d = StSqrt;
			end
			StSqrt: begin
				cmd.sqrt_step = 1'b1;
				if (stat.sqrt_last) state_d = StDvIni;
			end
			StDvIni: begin
				cmd.div_init = 1'b1;
				state_d = StDiv;
			end
			StDiv: begin
				cmd.div_step = 1'b1;
				if (stat.div_last) state_d = StFin;
			end
			StFin: begin
				if (out_free) begin
					cmd.finish = 1'b1;
					state_d = StIdle;
				end
			end
			default: state_d = StIdle;
		endcase
	end

	// State and output valid registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= StIdle;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.finish) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	`ASSERT_IMPL(a_onehot, clk, arst_n, 1'b1, $onehot(state_q), "state not one-hot")
	`ASSERT_IMPL(a_fin_free, clk, arst_n, cmd.finish, out_free, "result overwritten")
	`ASSERT_NEXT(a_fin_valid, clk, arst_n, cmd.finish, out_valid_q, "result not shown")

endmodule

FILE: sv/pmpp_dp.sv
`timescale 1ns / 1ps
// Datapath of the post-processor: scaling multipliers, bit-serial square
// root, restoring divider and energy accumulator. Depends on pmpp_pkg and assert_macros.svh.
module pmpp_dp (
	input  logic                         clk,
	input  logic                         arst_n,
	input  pmpp_pkg::pmpp_cmd_t          cmd,
	output pmpp_pkg::pmpp_stat_t         stat,
	input  logic [pmpp_pkg::GainW-1:0]   active_gain,
	input  logic [pmpp_pkg::GainW-1:0]   reactive_gain,
	input  logic [pmpp_pkg::GainW-1:0]   energy_gain,
	input  logic [pmpp_pkg::RawW-1:0]    active_power_raw,
	input  logic [pmpp_pkg::RawW-1:0]    reactive_pwr_raw,
	input  logic [pmpp_pkg::RawW-1:0]    energy_raw,
	input  logic                         clear_energy,
	output logic signed [pmpp_pkg::PowW-1:0] active_power,
	output logic signed [pmpp_pkg::PowW-1:0] reactive_pwr,
	output logic [pmpp_pkg::AppW-1:0]    apparent_power,
	output logic signed [pmpp_pkg::PfW-1:0]  power_factor,
	output logic signed [pmpp_pkg::AccW-1:0] energy_total,
	output logic                         energy_saturated
);
	import pmpp_pkg::*;
	`include "assert_macros.svh"

	localparam logic signed [AccW:0] AccMax = {2'b00, {(AccW-1){1'b1}}};
	localparam logic signed [AccW:0] AccMin = {2'b11, {(AccW-1){1'b0}}};

	logic [RawW-1:0] act_raw_q, rea_raw_q, en_raw_q;
	logic            clr_q;
	logic signed [PowW-1:0] act_q, rea_q, inc_q;
	logic [SqW-1:0]  sq_a_q, sq_r_q, num_q, rem_q;
	logic [AppW-1:0] root_q;
	logic [5:0]      cnt_q;
	logic [DivW-1:0] dnum_q;
	logic [AppW:0]   drem_q;
	logic [DivW-1:0] quo_q;
	logic signed [AccW-1:0] acc_q;

	// Scaled product of a sign-extended reading; >>> floors toward minus infinity.
	function automatic logic signed [PowW-1:0] scale(input logic [RawW-1:0] r,
		input logic [GainW-1:0] g);
		logic signed [RawW+GainW:0] p;
		p = $signed(r) * $signed({1'b0, g});
		return PowW'(p >>> 16);
	endfunction

	function automatic logic [PowW-1:0] mag(input logic signed [PowW-1:0] v);
		return v[PowW-1] ? PowW'(-v) : PowW'(v);
	endfunction

	// Squares are built from 40 by 20 bit partial products: low half in sq_add, high half added in sq_hi.
	logic [PowW-1:0]       mag_a, mag_r;
	logic [HalfW-1:0]      half_a, half_r;
	logic [PowW+HalfW-1:0] part_a, part_r;
	assign mag_a  = mag(act_q);
	assign mag_r  = mag(rea_q);
	assign half_a = cmd.sq_hi ? mag_a[PowW-1:HalfW] : mag_a[HalfW-1:0];
	assign half_r = cmd.sq_hi ? mag_r[PowW-1:HalfW] : mag_r[HalfW-1:0];
	assign part_a = {{HalfW{1'b0}}, mag_a} * {{PowW{1'b0}}, half_a};
	assign part_r = {{HalfW{1'b0}}, mag_r} * {{PowW{1'b0}}, half_r};

	// Bit-serial restoring square root, two radicand bits per step.
	logic [SqW-1:0] trial;
	logic [SqW-1:0] rem_sh;
	assign rem_sh = {rem_q[SqW-3:0], num_q[SqW-1 -: 2]};
	assign trial  = SqW'({root_q, 2'b01});

	// Restoring divider step.
	logic [AppW+1:0] dtrial;
	assign dtrial = {drem_q, dnum_q[DivW-1]} - {1'b0, root_q};

	assign stat.sqrt_last = (cnt_q == 6'(SqrtSteps-1));
	assign stat.div_last  = (cnt_q == 6'(DivSteps-1));

	// Energy sum with saturation.
	logic signed [AccW:0] sum;
	logic signed [AccW-1:0] acc_base;
	assign acc_base = clr_q ? '0 : acc_q;
	assign sum = $signed({acc_base[AccW-1], acc_base}) +
		$signed({{(AccW-PowW+1){inc_q[PowW-1]}}, inc_q});

	logic [DivW-1:0] q_clip;
	assign q_clip = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			cnt_q <= '0;
		end else begin
			if (cmd.sqrt_init || cmd.div_init) cnt_q <= '0;
			else if (cmd.sqrt_step || cmd.div_step) cnt_q <= cnt_q + 6'd1;
			if (cmd.finish) begin
				if (sum > AccMax) acc_q <= AccMax[AccW-1:0];
				else if (sum < AccMin) acc_q <= AccMin[AccW-1:0];
				else acc_q <= sum[AccW-1:0];
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_raw_q <= active_power_raw;
			rea_raw_q <= reactive_pwr_raw;
			en_raw_q  <= energy_raw;
			clr_q     <= clear_energy;
		end
		if (cmd.scale) begin
			act_q <= scale(act_raw_q, active_gain);
			rea_q <= scale(rea_raw_q, reactive_gain);
			inc_q <= scale(en_raw_q, energy_gain);
		end
		if (cmd.sq_add) begin
			sq_a_q <= SqW'(part_a);
			sq_r_q <= SqW'(part_r);
		end
		if (cmd.sq_hi) begin
			sq_a_q <= sq_a_q + (SqW'(part_a) << HalfW);
			sq_r_q <= sq_r_q + (SqW'(part_r) << HalfW);
		end
		if (cmd.sqrt_init) begin
			num_q  <= sq_a_q + sq_r_q;
			rem_q  <= '0;
			root_q <= '0;
		end
		if (cmd.sqrt_step) begin
			num_q <= {num_q[SqW-3:0], 2'b00};
			if (rem_sh >= trial) begin
				rem_q  <= rem_sh - trial;
				root_q <= {root_q[AppW-2:0], 1'b1};
			end else begin
				rem_q  <= rem_sh;
				root_q <= {root_q[AppW-2:0], 1'b0};
			end
		end
		if (cmd.div_init) begin
			dnum_q <= DivW'({mag(act_q), 15'd0});
			drem_q <= '0;
			quo_q  <= '0;
		end
		if (cmd.div_step) begin
			dnum_q <= {dnum_q[DivW-2:0], 1'b0};
			if (!dtrial[AppW+1]) begin
				drem_q <= dtrial[AppW:0];
				quo_q  <= {quo_q[DivW-2:0], 1'b1};
			end else begin
				drem_q <= {drem_q[AppW-1:0], dnum_q[DivW-1]};
				quo_q  <= {quo_q[DivW-2:0], 1'b0};
			end
		end
		if (cmd.finish) begin
			active_power    <= act_q;
			reactive_pwr    <= rea_q;
			apparent_power  <= root_q;
			energy_saturated <= (sum > AccMax) || (sum < AccMin);
			if (sum > AccMax) energy_total <= AccMax[AccW-1:0];
			else if (sum < AccMin) energy_total <= AccMin[AccW-1:0];
			else energy_total <= sum[AccW-1:0];
			if (act_q == '0 || root_q == '0) power_factor <= '0;
			else if (!act_q[PowW-1])
				power_factor <= (q_clip > DivW'(32767)) ? PfMax : PfW'(q_clip);
			else
				power_factor <= (q_clip > DivW'(32768)) ? PfMin : PfW'(-q_clip);
		end
	end

endmodule

FILE: sv/power_meter_post_processor_top.sv
`timescale 1ns / 1ps
// Top level of the power meter post-processor: APB register file plus the
// controller and datapath. Depends on pmpp_pkg, pmpp_ctrl and pmpp_dp.
//
// Usage:
// - Input channel: in_valid/in_stall carry raw active, reactive and energy
//   readings and a clear flag; a transfer happens when valid is high and
//   stall is low. The block takes one item at a time.
// - Output channel: out_valid/out_stall carry scaled powers, apparent
//   power, power factor and the energy total with its saturation flag.
// - After an input transfer the block scales the readings, forms the squares
//   from low and high partial products, sets up the root, runs 41 square root
//   steps, sets up the divide, runs 56 divide steps and forms the result.
//   A new item is taken only once the last one is through, since the
//   bit-serial root and divide steps run one after the other.
// - If the receiver stalls, the finished item waits in the output register
//   and the next item may proceed up to its final cycle, then holds.
// - Reset clears the energy accumulator and sets each gain to 1.0 (0x00010000).
// - Gains are written over APB at byte addresses 0, 4 and 8.
module power_meter_post_processor_top (
	input  logic clk,
	input  logic arst_n,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [pmpp_pkg::AddrW-1:0] paddr,
	input  logic [pmpp_pkg::DataW-1:0] pwdata,
	output logic [pmpp_pkg::DataW-1:0] prdata,
	output logic pready,
	input  logic in_valid,
	output logic in_stall,
	input  logic [pmpp_pkg::RawW-1:0] active_power_raw,
	input  logic [pmpp_pkg::RawW-1:0] reactive_pwr_raw,
	input  logic [pmpp_pkg::RawW-1:0] energy_raw,
	input  logic clear_energy,
	output logic out_valid,
	input  logic out_stall,
	output logic signed [pmpp_pkg::PowW-1:0] active_power,
	output logic signed [pmpp_pkg::PowW-1:0] reactive_pwr,
	output logic [pmpp_pkg::AppW-1:0] apparent_power,
	output logic signed [pmpp_pkg::PfW-1:0] power_factor,
	output logic signed [pmpp_pkg::AccW-1:0] energy_total,
	output logic energy_saturated
);
	import pmpp_pkg::*;

	logic [GainW-1:0] act_gain_q, rea_gain_q, en_gain_q;
	pmpp_cmd_t  cmd;
	pmpp_stat_t stat;

	assign pready = 1'b1;

	// Gain register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_gain_q <= GainReset;
			rea_gain_q <= GainReset;
			en_gain_q  <= GainReset;
		end else if (psel && penable && pwrite) begin
			case (paddr)
				RegActiveGain:   act_gain_q <= pwdata;
				RegReactiveGain: rea_gain_q <= pwdata;
				RegEnergyGain:   en_gain_q  <= pwdata;
				default: ;
			endcase
		end
	end

	// Register read back.
	always_comb begin
		case (paddr)
			RegActiveGain:   prdata = act_gain_q;
			RegReactiveGain: prdata = rea_gain_q;
			RegEnergyGain:   prdata = en_gain_q;
			default:         prdata = '0;
		endcase
	end

	pmpp_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_stall, .out_valid, .out_stall, .cmd, .stat
	);

	pmpp_dp u_dp (
		.clk, .arst_n, .cmd, .stat,
		.active_gain(act_gain_q), .reactive_gain(rea_gain_q), .energy_gain(en_gain_q),
		.active_power_raw, .reactive_pwr_raw, .energy_raw, .clear_energy,
		.active_power, .reactive_pwr, .apparent_power, .power_factor,
		.energy_total, .energy_saturated
	);

endmodule
